/* hw/rtl/npt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package npt_pkg;

  localparam int ID_W   = 16;
  localparam int DIST_W = 17;
  localparam int TEX_W  = 8;
  localparam int CFG_W  = 9;
  localparam int IN_CW  = 8;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_TEXTURE_COUNT = 1'b0;

  localparam logic [CFG_W-1:0] TEX_COUNT_RST = 9'd16;
  localparam logic [CFG_W-1:0] TEX_COUNT_MAX = 9'd256;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IN_CW-1:0] coord_x;
    logic [IN_CW-1:0] coord_y;
    logic [ID_W-1:0]  object_id;
  } npt_in_t;

  typedef struct packed {
    logic              found;
    logic [TEX_W-1:0]  texture;
    logic [DIST_W-1:0] min_distance;
  } npt_out_t;

  typedef struct packed {
    logic              done;
    logic              have;
    logic [ID_W-1:0]   best_id;
    logic [DIST_W-1:0] best_d;
  } npt_scan_res_t;

endpackage

`default_nettype wire

/* hw/rtl/npt_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module npt_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [DW-1:0]      rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hw/rtl/npt_scan.sv */
`timescale 1ns / 1ps
`default_nettype none

module npt_scan #(
  parameter int CW   = 8,
  parameter int AW   = 6,
  parameter int CNTW = 7
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [CW-1:0]          qx,
  input  wire logic [CW-1:0]          qy,
  input  wire logic [CNTW-1:0]        count,
  output logic                        rd_en,
  output logic [AW-1:0]               rd_addr,
  input  wire logic [2*CW+npt_pkg::ID_W-1:0] rd_data,
  output npt_pkg::npt_scan_res_t      res
);

  localparam int DWD = 2 * CW + 1;

  logic                  issuing_r;
  logic [CNTW-1:0]       iss_r;
  logic [CNTW-1:0]       cnt_r;
  logic [CW-1:0]         qx_r;
  logic [CW-1:0]         qy_r;
  logic                  last_issue;

  logic                  v1_r, last1_r;
  logic                  v2_r, last2_r;
  logic                  v3_r, last3_r;
  logic [CW-1:0]         dx_r, dy_r;
  logic [npt_pkg::ID_W-1:0] id2_r, id3_r;
  logic [DWD-1:0]        d_r;

  logic [CW-1:0]         px, py;
  logic [npt_pkg::ID_W-1:0] pid;
  logic [2*CW-1:0]       sqx, sqy;

  logic                  have_r;
  logic [DWD-1:0]        best_d_r;
  logic [npt_pkg::ID_W-1:0] best_id_r;
  logic                  done_r, done_nxt;
  logic                  take;

  assign last_issue = (iss_r + CNTW'(1)) == cnt_r;
  assign rd_en      = issuing_r;
  assign rd_addr    = iss_r[AW-1:0];

  assign {px, py, pid} = rd_data;

  assign sqx = (2*CW)'(dx_r) * (2*CW)'(dx_r);
  assign sqy = (2*CW)'(dy_r) * (2*CW)'(dy_r);

  assign take     = v3_r && (!have_r || (d_r < best_d_r));
  assign done_nxt = (start && (count == '0)) || (v3_r && last3_r);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      iss_r     <= '0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      last1_r   <= 1'b0;
      last2_r   <= 1'b0;
      last3_r   <= 1'b0;
      have_r    <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (start) begin
        issuing_r <= (count != '0);
        iss_r     <= '0;
      end else if (issuing_r) begin
        iss_r <= iss_r + CNTW'(1);
        if (last_issue) begin
          issuing_r <= 1'b0;
        end
      end
      v1_r    <= issuing_r;
      last1_r <= issuing_r && last_issue;
      v2_r    <= v1_r;
      last2_r <= last1_r;
      v3_r    <= v2_r;
      last3_r <= last2_r;
      if (start) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      qx_r  <= qx;
      qy_r  <= qy;
      cnt_r <= count;
    end
    dx_r  <= (qx_r > px) ? (qx_r - px) : (px - qx_r);
    dy_r  <= (qy_r > py) ? (qy_r - py) : (py - qy_r);
    id2_r <= pid;
    d_r   <= DWD'(sqx) + DWD'(sqy);
    id3_r <= id2_r;
    if (take) begin
      best_d_r  <= d_r;
      best_id_r <= id3_r;
    end
  end

  assign res.done    = done_r;
  assign res.have    = have_r;
  assign res.best_id = best_id_r;
  assign res.best_d  = npt_pkg::DIST_W'(best_d_r);

endmodule

`default_nettype wire

/* hw/rtl/npt_mod.sv */
`timescale 1ns / 1ps
`default_nettype none

module npt_mod (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [npt_pkg::ID_W-1:0]  dividend,
  input  wire logic [npt_pkg::CFG_W-1:0] divisor,
  output logic                           done,
  output logic [npt_pkg::TEX_W-1:0]      rem
);

  localparam int STEPS = npt_pkg::ID_W;
  localparam int SW    = $clog2(STEPS);

  logic                      run_r;
  logic [SW-1:0]             step_r;
  logic [npt_pkg::ID_W-1:0]  dvd_r;
  logic [npt_pkg::TEX_W-1:0] rem_r, rem_nxt;
  logic [npt_pkg::CFG_W-1:0] div_r;
  logic                      zero_r;
  logic                      done_r;
  logic [npt_pkg::CFG_W-1:0] trial;

  // restoring step, one quotient bit a cycle; remainder stays below 256
  assign trial   = {rem_r, dvd_r[npt_pkg::ID_W-1]};
  assign rem_nxt = (trial >= div_r) ? npt_pkg::TEX_W'(trial - div_r)
                                    : npt_pkg::TEX_W'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        step_r <= step_r + SW'(1);
        if (step_r == SW'(STEPS - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
      zero_r <= (divisor == '0);
    end else if (run_r) begin
      dvd_r <= {dvd_r[npt_pkg::ID_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = zero_r ? '0 : rem_r;

endmodule

`default_nettype wire

/* hw/rtl/nearest_point_tile_labeler.sv */
// query: one entry read a cycle from the start transfer, then a 16-step modulo unit;
//   an empty store skips the modulo unit and answers once the scan is done
// busy drops with the strobe, so a new query is taken only after the last result
// clear and insert: taken back to back, busy stays low, no result
// the result strobe lasts one cycle; the receiver cannot stall
// rst_n (synchronous, active low) empties the store and sets texture_count to 16
`timescale 1ns / 1ps
`default_nettype none

module nearest_point_tile_labeler #(
  parameter int MAX_POINTS      = 64,
  parameter int TILE_COORD_BITS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // command channel
  input  wire logic             start,
  output logic                  busy,
  input  wire npt_pkg::npt_in_t in_data,
  // result channel
  output logic                  out_valid,
  output npt_pkg::npt_out_t     out_data,
  // register port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // coordinates arrive on 8 bits and are kept to the tile width
  localparam int CW   = (TILE_COORD_BITS < npt_pkg::IN_CW) ? TILE_COORD_BITS
                                                            : npt_pkg::IN_CW;
  localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int DW   = 2 * CW + npt_pkg::ID_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;

  logic [1:0]                state_r;
  logic [CNTW-1:0]           count_r;
  logic [npt_pkg::CFG_W-1:0] tex_count_r;
  logic                      out_valid_r;
  npt_pkg::npt_out_t         out_r;

  logic                      accept;
  logic                      is_clear, is_insert, is_query;
  logic                      full;
  logic                      mem_wr;
  logic [CW-1:0]             qx, qy;
  logic [npt_pkg::CFG_W-1:0] modulus;
  logic                      cfg_wr;

  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [DW-1:0]             rd_data;
  npt_pkg::npt_scan_res_t    scan_res;
  logic                      mod_start;
  logic                      mod_done;
  logic [npt_pkg::TEX_W-1:0] mod_rem;

  // command transfer and decode
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign is_clear  = accept && (in_data.req_type == npt_pkg::REQ_CLEAR);
  assign is_insert = accept && (in_data.req_type == npt_pkg::REQ_INSERT);
  assign is_query  = accept && (in_data.req_type == npt_pkg::REQ_QUERY);

  assign full   = (count_r == CNTW'(MAX_POINTS));
  assign mem_wr = is_insert && !full;
  assign qx     = in_data.coord_x[CW-1:0];
  assign qy     = in_data.coord_y[CW-1:0];

  // texture count above 256 behaves as 256; zero is caught in the modulo unit
  assign modulus = (tex_count_r > npt_pkg::TEX_COUNT_MAX) ? npt_pkg::TEX_COUNT_MAX
                                                          : tex_count_r;

  // point memory: x, y and id side by side in one word, appended at the fill count.
  // an insert into a store that is not full writes at its transfer edge, so a following query always reads it
  npt_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({qx, qy, in_data.object_id}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // nearest-point scan, earliest point kept on equal distance
  npt_scan #(
    .CW   (CW),
    .AW   (AW),
    .CNTW (CNTW)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (is_query),
    .qx      (qx),
    .qy      (qy),
    .count   (count_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (scan_res)
  );

  assign mod_start = (state_r == ST_SCAN) && scan_res.done && scan_res.have;

  npt_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (scan_res.best_id),
    .divisor  (modulus),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (is_clear) begin
        count_r <= '0;
      end else if (mem_wr) begin
        count_r <= count_r + CNTW'(1);
      end
      case (state_r)
        ST_IDLE: begin
          if (is_query) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (scan_res.done) begin
            if (scan_res.have) begin
              state_r <= ST_MOD;
            end else begin
              // empty store answers at once
              state_r     <= ST_IDLE;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            state_r     <= ST_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_SCAN) && scan_res.done && !scan_res.have) begin
      out_r <= '0;
    end else if ((state_r == ST_MOD) && mod_done) begin
      out_r.found        <= 1'b1;
      out_r.texture      <= mod_rem;
      out_r.min_distance <= scan_res.best_d;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // register port: texture_count at byte address 0, no wait states
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == npt_pkg::REG_TEXTURE_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_count_r <= npt_pkg::TEX_COUNT_RST;
    end else if (cfg_wr) begin
      tex_count_r <= pwdata[npt_pkg::CFG_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == npt_pkg::REG_TEXTURE_COUNT)
                  ? {{(32 - npt_pkg::CFG_W){1'b0}}, tex_count_r} : '0;

endmodule

`default_nettype wire

/* hw/rtl/npt_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

module npt_chk (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire npt_pkg::npt_in_t  in_data,
  input wire logic              out_valid,
  input wire npt_pkg::npt_out_t out_data
);

  // a query holds the block until its result
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.req_type == npt_pkg::REQ_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  // clear, insert and unknown codes finish in the cycle they are taken
  a_other_free: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.req_type != npt_pkg::REQ_QUERY) |=> !busy)
    else $error("non-query transfer raised busy");

  // a result only ends a query's busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a query in flight");

  // one strobe per query
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // empty store answers with zeros
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> (out_data.texture == '0)
                                    && (out_data.min_distance == '0))
    else $error("not-found result carries nonzero fields");

endmodule

bind nearest_point_tile_labeler npt_chk u_npt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
